[rtl/core/abds_pkg.sv]
package abds_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAX_AXES   = 3;
    localparam int SQ_BITS    = 34;
    localparam int AXIS_BITS  = 2;
    localparam int REQ_BITS   = 3;

    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_BUILD = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_POINT = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_PRIM  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_SPLIT = 3'd4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    // one bit wider: extents and bound sums
    typedef logic signed [COORD_BITS:0]   wide_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [REQ_BITS-1:0] req_type;
        coord_t              px;
        coord_t              py;
        coord_t              pz;
        logic                last_vertex;
    } req_item_t;

    typedef struct packed {
        logic [SQ_BITS-1:0]   sq_dist;
        logic                 inside_res;
        logic [AXIS_BITS-1:0] split_axis;
        coord_t               split_center;
        logic                 goes_left;
    } res_item_t;

    typedef struct packed {
        logic                upd;
        logic [REQ_BITS-1:0] req;
        logic                last;
        logic                adv1;
        logic                adv2;
    } lane_ctl_t;

    typedef struct packed {
        wide_t                   extent;
        wide_t                   bsum;
        coord_t                  coord;
        logic                    outside;
        logic [2*COORD_BITS-1:0] sq;
    } lane_res_t;

endpackage

[rtl/core/abds_lane.sv]
module abds_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abds_pkg::lane_ctl_t  ctl,
    input  abds_pkg::coord_t     coord,
    output abds_pkg::lane_res_t  res
);

    localparam int CB = abds_pkg::COORD_BITS;

    abds_pkg::coord_t lo_reg, hi_reg, plo_reg, phi_reg;
    abds_pkg::coord_t lo_next, hi_next, plo_next, phi_next;

    abds_pkg::coord_t grow_lo, grow_hi, pgrow_lo, pgrow_hi;
    abds_pkg::coord_t box_lo, box_hi, a_lo, a_hi;
    logic             below, above, take_below;
    abds_pkg::wide_t  d_below, d_above;

    abds_pkg::wide_t   ext1_reg, ext1_next;
    abds_pkg::wide_t   sum1_reg, sum1_next;
    abds_pkg::coord_t  coord1_reg;
    logic              out1_reg, out1_next;
    logic [CB-1:0]     diff1_reg, diff1_next;
    logic [2*CB-1:0]   sq2_reg, sq2_next;

    always_comb
    begin
        grow_lo  = (coord < lo_reg)  ? coord : lo_reg;
        grow_hi  = (coord > hi_reg)  ? coord : hi_reg;
        pgrow_lo = (coord < plo_reg) ? coord : plo_reg;
        pgrow_hi = (coord > phi_reg) ? coord : phi_reg;

        lo_next  = lo_reg;
        hi_next  = hi_reg;
        plo_next = plo_reg;
        phi_next = phi_reg;
        if (ctl.upd)
        begin
            case (ctl.req)
                abds_pkg::REQ_CLEAR:
                begin
                    lo_next  = abds_pkg::COORD_MAX;
                    hi_next  = abds_pkg::COORD_MIN;
                    plo_next = abds_pkg::COORD_MAX;
                    phi_next = abds_pkg::COORD_MIN;
                end
                abds_pkg::REQ_BUILD:
                begin
                    lo_next = grow_lo;
                    hi_next = grow_hi;
                end
                abds_pkg::REQ_PRIM:
                begin
                    // last vertex reports and then empties the primitive box
                    plo_next = ctl.last ? abds_pkg::COORD_MAX : pgrow_lo;
                    phi_next = ctl.last ? abds_pkg::COORD_MIN : pgrow_hi;
                end
                default:
                begin
                end
            endcase
        end

        // box as seen after this item
        box_lo = (ctl.req == abds_pkg::REQ_BUILD) ? grow_lo : lo_reg;
        box_hi = (ctl.req == abds_pkg::REQ_BUILD) ? grow_hi : hi_reg;
        ext1_next = abds_pkg::wide_t'(box_hi) - abds_pkg::wide_t'(box_lo);
        sum1_next = abds_pkg::wide_t'(box_hi) + abds_pkg::wide_t'(box_lo);

        // probe interval: the point itself or the grown primitive box
        a_lo = (ctl.req == abds_pkg::REQ_PRIM) ? pgrow_lo : coord;
        a_hi = (ctl.req == abds_pkg::REQ_PRIM) ? pgrow_hi : coord;
        below = a_hi < lo_reg;
        above = a_lo > hi_reg;
        // empty box can make both true: point checks below first, primitive above first
        take_below = (ctl.req == abds_pkg::REQ_PRIM) ? (below && !above) : below;
        d_below = abds_pkg::wide_t'(lo_reg) - abds_pkg::wide_t'(a_hi);
        d_above = abds_pkg::wide_t'(a_lo) - abds_pkg::wide_t'(hi_reg);
        out1_next = below || above;
        if (take_below)
            diff1_next = d_below[CB-1:0];
        else if (above)
            diff1_next = d_above[CB-1:0];
        else
            diff1_next = '0;

        sq2_next = (2*CB)'(diff1_reg) * (2*CB)'(diff1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= abds_pkg::COORD_MAX;
            hi_reg  <= abds_pkg::COORD_MIN;
            plo_reg <= abds_pkg::COORD_MAX;
            phi_reg <= abds_pkg::COORD_MIN;
        end
        else
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            ext1_reg   <= ext1_next;
            sum1_reg   <= sum1_next;
            coord1_reg <= coord;
            out1_reg   <= out1_next;
            diff1_reg  <= diff1_next;
        end
        if (ctl.adv2)
            sq2_reg <= sq2_next;
    end

    assign res.extent  = ext1_reg;
    assign res.bsum    = sum1_reg;
    assign res.coord   = coord1_reg;
    assign res.outside = out1_reg;
    assign res.sq      = sq2_reg;

endmodule

[rtl/core/abds_merge.sv]
module abds_merge #(
    parameter int AXES = 3
) (
    input  logic                                 clk,
    input  logic [abds_pkg::REQ_BITS-1:0]        req1,
    input  logic                                 adv2,
    input  logic                                 adv3,
    input  abds_pkg::lane_res_t                  lanes [AXES],
    output abds_pkg::res_item_t                  item
);

    localparam int CB = abds_pkg::COORD_BITS;

    logic [abds_pkg::AXIS_BITS-1:0] best;
    abds_pkg::wide_t                best_ext;
    abds_pkg::wide_t                best_sum;
    abds_pkg::coord_t               best_coord;
    abds_pkg::wide_t                half;
    abds_pkg::coord_t               center;
    logic                           all_in;

    logic [abds_pkg::REQ_BITS-1:0]  req2_reg;
    logic [abds_pkg::AXIS_BITS-1:0] axis2_reg;
    abds_pkg::coord_t               center2_reg;
    logic                           left2_reg, inside2_reg;

    logic [abds_pkg::SQ_BITS-1:0]   acc;
    abds_pkg::res_item_t            item_next, item_reg;

    always_comb
    begin
        best       = '0;
        best_ext   = lanes[0].extent;
        best_sum   = lanes[0].bsum;
        best_coord = lanes[0].coord;
        all_in     = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            // strict compare keeps the lowest axis on ties
            if (a > 0 && lanes[a].extent > best_ext)
            begin
                best       = abds_pkg::AXIS_BITS'(a);
                best_ext   = lanes[a].extent;
                best_sum   = lanes[a].bsum;
                best_coord = lanes[a].coord;
            end
            if (lanes[a].outside)
                all_in = 1'b0;
        end
        half   = best_sum >>> 1;
        center = half[CB-1:0];

        acc = '0;
        for (int a = 0; a < AXES; a++)
            acc = acc + abds_pkg::SQ_BITS'(lanes[a].sq);

        item_next = '0;
        case (req2_reg)
            abds_pkg::REQ_BUILD:
            begin
                item_next.split_axis   = axis2_reg;
                item_next.split_center = center2_reg;
            end
            abds_pkg::REQ_POINT:
            begin
                item_next.sq_dist    = acc;
                item_next.inside_res = inside2_reg;
            end
            abds_pkg::REQ_PRIM:
                item_next.sq_dist = acc;
            abds_pkg::REQ_SPLIT:
            begin
                item_next.split_axis   = axis2_reg;
                item_next.split_center = center2_reg;
                item_next.goes_left    = left2_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            req2_reg    <= req1;
            axis2_reg   <= best;
            center2_reg <= center;
            left2_reg   <= best_coord < center;
            inside2_reg <= all_in;
        end
        if (adv3)
            item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

[rtl/core/aabb_build_distance_split_top.sv]
// Channel | Valid     | Stall     | Payload             | Transfer when
// request | req_valid | req_stall | req_data (req_item) | req_valid && !req_stall
// result  | res_valid | res_stall | res_data (res_item) | res_valid && !res_stall
//
// One item per cycle sustained while res_stall is low. Three register stages: lane compare/subtract (loaded at
// the request transfer), per-lane 16x16 square with axis pick, sum and result select. res_valid rises
// once the item reaches the result register, and the result transfers while res_stall is low.
// Box state updates at the request transfer, so the next item sees it at once.
// Reset empties both boxes and drains the pipeline; no clearing pass.
// A stalled result backs up stage by stage; bubbles are absorbed before req_stall rises.
module aabb_build_distance_split_top #(
    parameter int AXES = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  abds_pkg::req_item_t req_data,
    output logic                res_valid,
    input  logic                res_stall,
    output abds_pkg::res_item_t res_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;
    logic xfer, has_result;
    logic [abds_pkg::REQ_BITS-1:0] req1_reg;

    abds_pkg::lane_ctl_t ctl;
    abds_pkg::coord_t    lane_coord [AXES];
    abds_pkg::lane_res_t lane_out   [AXES];

    assign rdy3 = !v3_reg || !res_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign req_stall = !rdy1;
    assign xfer = req_valid && rdy1;

    always_comb
    begin
        case (req_data.req_type)
            abds_pkg::REQ_POINT, abds_pkg::REQ_SPLIT:
                has_result = 1'b1;
            abds_pkg::REQ_BUILD, abds_pkg::REQ_PRIM:
                has_result = req_data.last_vertex;
            default:
                has_result = 1'b0;
        endcase

        v1_next = rdy1 ? (xfer && has_result) : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;

        ctl.upd  = xfer;
        ctl.req  = req_data.req_type;
        ctl.last = req_data.last_vertex;
        ctl.adv1 = rdy1;
        ctl.adv2 = rdy2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            req1_reg <= req_data.req_type;
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        if (g == 0)
        begin : g_x
            assign lane_coord[g] = req_data.px;
        end
        else if (g == 1)
        begin : g_y
            assign lane_coord[g] = req_data.py;
        end
        else
        begin : g_z
            assign lane_coord[g] = req_data.pz;
        end

        abds_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .coord (lane_coord[g]),
            .res   (lane_out[g])
        );
    end

    abds_merge #(
        .AXES (AXES)
    ) u_merge (
        .clk   (clk),
        .req1  (req1_reg),
        .adv2  (rdy2),
        .adv3  (rdy3),
        .lanes (lane_out),
        .item  (res_data)
    );

    assign res_valid = v3_reg;

endmodule
